/* hdl/gda_pkg.sv */
// Shared types, microcode ROM and calendar helpers for the Gregorian date unit.
package gda_pkg;

    localparam int YEAR_LIMIT_DEF = 9999;

    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;
    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int CNT_W  = 22;
    localparam int SPAN_W = 22;

    // Walking year: input year plus the longest add still fits in 16 bits.
    localparam int YR_W   = 16;
    // Day accumulator: covers a full-range span and day-of-year plus count.
    localparam int ACC_W  = 24;
    localparam int R400_W = 9;
    localparam int DOY_W  = 9;
    localparam int PC_W   = 5;
    localparam int K_W    = 3;
    // 400 << 5 is the largest power-of-two multiple of 400 that fits a 14-bit year.
    localparam logic [K_W-1:0] RED_TOP = K_W'(5);
    localparam logic [MON_W-1:0] MONTHS = MON_W'(12);
    localparam logic [R400_W-1:0] CYCLE_LAST = R400_W'(399);

    typedef enum logic [FUNC_W-1:0] {
        FN_VALIDATE,
        FN_ADD,
        FN_DIFF,
        FN_UNUSED
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_INVALID,
        ST_OVERFLOW,
        ST_BEFORE
    } status_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_REDUCE,
        OP_CHECK_A,
        OP_LOAD_B,
        OP_CHECK_B,
        OP_SPAN_INIT,
        OP_YEAR_ACC,
        OP_ADD_CNT,
        OP_YEAR_SUB,
        OP_MON_INIT,
        OP_MON_SUB,
        OP_FIN_ST,
        OP_FIN_ADD,
        OP_FIN_SPAN
    } op_t;

    typedef enum logic [3:0] {
        CND_NONE,
        CND_ALWAYS,
        CND_K_NZ,
        CND_A_BAD,
        CND_FN_VAL,
        CND_FN_ADD,
        CND_FN_UNUSED,
        CND_B_BAD,
        CND_B_BEFORE,
        CND_YR_NE_B,
        CND_YEAR_MORE,
        CND_YR_OVER,
        CND_MON_MORE
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
        status_t          status;
    } uword_t;

    // Microprogram addresses
    localparam logic [PC_W-1:0] S_IDLE      = PC_W'(0);
    localparam logic [PC_W-1:0] S_RED_A     = PC_W'(1);
    localparam logic [PC_W-1:0] S_CHK_A     = PC_W'(2);
    localparam logic [PC_W-1:0] S_DISP_VAL  = PC_W'(3);
    localparam logic [PC_W-1:0] S_DISP_ADD  = PC_W'(4);
    localparam logic [PC_W-1:0] S_DISP_BAD  = PC_W'(5);
    localparam logic [PC_W-1:0] S_LOAD_B    = PC_W'(6);
    localparam logic [PC_W-1:0] S_RED_B     = PC_W'(7);
    localparam logic [PC_W-1:0] S_CHK_B     = PC_W'(8);
    localparam logic [PC_W-1:0] S_ORDER     = PC_W'(9);
    localparam logic [PC_W-1:0] S_SPAN_INIT = PC_W'(10);
    localparam logic [PC_W-1:0] S_SPAN_WALK = PC_W'(11);
    localparam logic [PC_W-1:0] S_FIN_SPAN  = PC_W'(12);
    localparam logic [PC_W-1:0] S_ADD_CNT   = PC_W'(13);
    localparam logic [PC_W-1:0] S_ADD_WALK  = PC_W'(14);
    localparam logic [PC_W-1:0] S_ADD_OVF   = PC_W'(15);
    localparam logic [PC_W-1:0] S_MON_WALK  = PC_W'(16);
    localparam logic [PC_W-1:0] S_FIN_ADD   = PC_W'(17);
    localparam logic [PC_W-1:0] S_FIN_OK    = PC_W'(18);
    localparam logic [PC_W-1:0] S_FIN_INV   = PC_W'(19);
    localparam logic [PC_W-1:0] S_FIN_OVF   = PC_W'(20);
    localparam logic [PC_W-1:0] S_FIN_BEF   = PC_W'(21);

    // Control store: taken condition jumps to target, else falls to pc + 1.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{OP_NOP, CND_ALWAYS, S_IDLE, ST_OK};
        unique case (pc)
            S_RED_A:     w = '{OP_REDUCE,    CND_K_NZ,      S_RED_A,     ST_OK};
            S_CHK_A:     w = '{OP_CHECK_A,   CND_A_BAD,     S_FIN_INV,   ST_OK};
            S_DISP_VAL:  w = '{OP_NOP,       CND_FN_VAL,    S_FIN_OK,    ST_OK};
            S_DISP_ADD:  w = '{OP_NOP,       CND_FN_ADD,    S_ADD_CNT,   ST_OK};
            S_DISP_BAD:  w = '{OP_NOP,       CND_FN_UNUSED, S_FIN_INV,   ST_OK};
            S_LOAD_B:    w = '{OP_LOAD_B,    CND_NONE,      S_IDLE,      ST_OK};
            S_RED_B:     w = '{OP_REDUCE,    CND_K_NZ,      S_RED_B,     ST_OK};
            S_CHK_B:     w = '{OP_CHECK_B,   CND_B_BAD,     S_FIN_INV,   ST_OK};
            S_ORDER:     w = '{OP_NOP,       CND_B_BEFORE,  S_FIN_BEF,   ST_OK};
            S_SPAN_INIT: w = '{OP_SPAN_INIT, CND_NONE,      S_IDLE,      ST_OK};
            S_SPAN_WALK: w = '{OP_YEAR_ACC,  CND_YR_NE_B,   S_SPAN_WALK, ST_OK};
            S_FIN_SPAN:  w = '{OP_FIN_SPAN,  CND_ALWAYS,    S_IDLE,      ST_OK};
            S_ADD_CNT:   w = '{OP_ADD_CNT,   CND_NONE,      S_IDLE,      ST_OK};
            S_ADD_WALK:  w = '{OP_YEAR_SUB,  CND_YEAR_MORE, S_ADD_WALK,  ST_OK};
            S_ADD_OVF:   w = '{OP_MON_INIT,  CND_YR_OVER,   S_FIN_OVF,   ST_OK};
            S_MON_WALK:  w = '{OP_MON_SUB,   CND_MON_MORE,  S_MON_WALK,  ST_OK};
            S_FIN_ADD:   w = '{OP_FIN_ADD,   CND_ALWAYS,    S_IDLE,      ST_OK};
            S_FIN_OK:    w = '{OP_FIN_ST,    CND_ALWAYS,    S_IDLE,      ST_OK};
            S_FIN_INV:   w = '{OP_FIN_ST,    CND_ALWAYS,    S_IDLE,      ST_INVALID};
            S_FIN_OVF:   w = '{OP_FIN_ST,    CND_ALWAYS,    S_IDLE,      ST_OVERFLOW};
            S_FIN_BEF:   w = '{OP_FIN_ST,    CND_ALWAYS,    S_IDLE,      ST_BEFORE};
            default:     w = '{OP_NOP,       CND_ALWAYS,    S_IDLE,      ST_OK};
        endcase
        return w;
    endfunction

    // Leap rule from year mod 400 and the two low year bits (year mod 4).
    function automatic logic is_leap(input logic [R400_W-1:0] r400, input logic [1:0] ylow);
        return ((ylow == 2'd0) && (r400 != R400_W'(100)) && (r400 != R400_W'(200))
                && (r400 != R400_W'(300))) || (r400 == '0);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
        logic [DAY_W-1:0] n;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    n = DAY_W'(30);
            4'd2:                                       n = leap ? DAY_W'(29) : DAY_W'(28);
            default:                                    n = '0;
        endcase
        return n;
    endfunction

    function automatic logic [DOY_W-1:0] days_before(input logic [MON_W-1:0] m);
        logic [DOY_W-1:0] n;
        unique case (m)
            4'd2:    n = DOY_W'(31);
            4'd3:    n = DOY_W'(59);
            4'd4:    n = DOY_W'(90);
            4'd5:    n = DOY_W'(120);
            4'd6:    n = DOY_W'(151);
            4'd7:    n = DOY_W'(181);
            4'd8:    n = DOY_W'(212);
            4'd9:    n = DOY_W'(243);
            4'd10:   n = DOY_W'(273);
            4'd11:   n = DOY_W'(304);
            4'd12:   n = DOY_W'(334);
            default: n = '0;
        endcase
        return n;
    endfunction

    // Zero-based day of year of a valid date.
    function automatic logic [DOY_W-1:0] day_of_year(input logic [DAY_W-1:0] d,
                                                     input logic [MON_W-1:0] m,
                                                     input logic leap);
        logic [DOY_W-1:0] extra;
        extra = ((m > MON_W'(2)) && leap) ? DOY_W'(1) : DOY_W'(0);
        return days_before(m) + DOY_W'(d) - DOY_W'(1) + extra;
    endfunction

    function automatic logic [DOY_W-1:0] year_len(input logic leap);
        return leap ? DOY_W'(366) : DOY_W'(365);
    endfunction

    function automatic logic date_ok(input logic [DAY_W-1:0] d, input logic [MON_W-1:0] m,
                                     input logic [YEAR_W-1:0] y, input logic leap,
                                     input logic [YR_W-1:0] limit);
        return (YR_W'(y) <= limit) && (m >= MON_W'(1)) && (m <= MONTHS)
               && (d != '0) && (d <= month_len(m, leap));
    endfunction

    // Multiple of 400 tried at reduction step k.
    function automatic logic [YEAR_W-1:0] red_sub(input logic [K_W-1:0] k);
        return YEAR_W'(400) << k;
    endfunction

endpackage

/* hdl/gregorian_date_arithmetic.sv */
// Gregorian date unit: validate, add days, day difference; microcoded sequencer.
// Add walks the years rolled over, then at most 11 months; difference walks the
// years from year_a to year_b. Year walks move one year per cycle; one request at
// a time, next start taken in the done cycle.
// rst_n is asynchronous: it returns the sequencer to idle and drops done.
module gregorian_date_arithmetic #(
    parameter int YEAR_LIMIT = gda_pkg::YEAR_LIMIT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [gda_pkg::FUNC_W-1:0]  func,
    input  logic [gda_pkg::DAY_W-1:0]   day_a,
    input  logic [gda_pkg::MON_W-1:0]   month_a,
    input  logic [gda_pkg::YEAR_W-1:0]  year_a,
    input  logic [gda_pkg::DAY_W-1:0]   day_b,
    input  logic [gda_pkg::MON_W-1:0]   month_b,
    input  logic [gda_pkg::YEAR_W-1:0]  year_b,
    input  logic [gda_pkg::CNT_W-1:0]   day_count,
    output logic                        done,
    output logic [gda_pkg::STAT_W-1:0]  status,
    output logic [gda_pkg::DAY_W-1:0]   day_out,
    output logic [gda_pkg::MON_W-1:0]   month_out,
    output logic [gda_pkg::YEAR_W-1:0]  year_out,
    output logic [gda_pkg::SPAN_W-1:0]  day_span
);
    import gda_pkg::*;

    // Sequencer control
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic              done_reg, done_next;
    logic [K_W-1:0]    k_reg, k_next;

    // Latched request
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [DAY_W-1:0]  da_reg, da_next, db_reg, db_next;
    logic [MON_W-1:0]  ma_reg, ma_next, mb_reg, mb_next;
    logic [YEAR_W-1:0] ya_reg, ya_next, yb_reg, yb_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Datapath: remainder unit, walking year with its mod-400 phase, day accumulator
    logic [YEAR_W-1:0] rem_reg, rem_next;
    logic [R400_W-1:0] r400_reg, r400_next;
    logic              leap_b_reg, leap_b_next;
    logic [YR_W-1:0]   yr_reg, yr_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [MON_W-1:0]  mon_reg, mon_next;

    // Result registers
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DAY_W-1:0]  day_out_reg, day_out_next;
    logic [MON_W-1:0]  month_out_reg, month_out_next;
    logic [YEAR_W-1:0] year_out_reg, year_out_next;
    logic [SPAN_W-1:0] day_span_reg, day_span_next;

    uword_t            cur;
    logic              accept;
    logic              taken;
    logic              leap_rem_a, leap_rem_b, leap_yr;
    logic [DOY_W-1:0]  ylen;
    logic [DAY_W-1:0]  mlen;
    logic [YR_W-1:0]   limit;
    logic              a_ok, b_ok, b_before, yr_ne_b, year_more, yr_over, mon_more;
    logic [R400_W-1:0] r400_inc;
    logic [YEAR_W-1:0] red_val;

    assign busy   = (pc_reg != S_IDLE);
    assign accept = start && !busy;
    assign cur    = ucode(pc_reg);
    assign limit  = YR_W'(YEAR_LIMIT);

    // rem_reg holds year mod 400 once a reduction loop has run out.
    assign leap_rem_a = is_leap(rem_reg[R400_W-1:0], ya_reg[1:0]);
    assign leap_rem_b = is_leap(rem_reg[R400_W-1:0], yb_reg[1:0]);
    assign leap_yr    = is_leap(r400_reg, yr_reg[1:0]);
    assign ylen       = year_len(leap_yr);
    assign mlen       = month_len(mon_reg, leap_yr);
    assign red_val    = red_sub(k_reg);
    assign r400_inc   = (r400_reg == CYCLE_LAST) ? '0 : r400_reg + R400_W'(1);

    assign a_ok      = date_ok(da_reg, ma_reg, ya_reg, leap_rem_a, limit);
    assign b_ok      = date_ok(db_reg, mb_reg, yb_reg, leap_rem_b, limit);
    // Both dates are valid here, so field order is date order.
    assign b_before  = {yb_reg, mb_reg, db_reg} < {ya_reg, ma_reg, da_reg};
    assign yr_ne_b   = (yr_reg != YR_W'(yb_reg));
    assign year_more = (acc_reg >= ACC_W'(ylen));
    assign yr_over   = (yr_reg > limit);
    assign mon_more  = (mon_reg < MONTHS) && (acc_reg >= ACC_W'(mlen));

    // Jump condition select
    always_comb
    begin
        unique case (cur.cond)
            CND_NONE:      taken = 1'b0;
            CND_ALWAYS:    taken = 1'b1;
            CND_K_NZ:      taken = (k_reg != '0);
            CND_A_BAD:     taken = !a_ok;
            CND_FN_VAL:    taken = (func_reg == FN_VALIDATE);
            CND_FN_ADD:    taken = (func_reg == FN_ADD);
            CND_FN_UNUSED: taken = (func_reg == FN_UNUSED);
            CND_B_BAD:     taken = !b_ok;
            CND_B_BEFORE:  taken = b_before;
            CND_YR_NE_B:   taken = yr_ne_b;
            CND_YEAR_MORE: taken = year_more;
            CND_YR_OVER:   taken = yr_over;
            CND_MON_MORE:  taken = mon_more;
            default:       taken = 1'b0;
        endcase
    end

    // Datapath controlled by the current control word
    always_comb
    begin
        pc_next        = taken ? cur.target : pc_reg + PC_W'(1);
        done_next      = 1'b0;
        k_next         = k_reg;
        func_next      = func_reg;
        da_next        = da_reg;
        ma_next        = ma_reg;
        ya_next        = ya_reg;
        db_next        = db_reg;
        mb_next        = mb_reg;
        yb_next        = yb_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        r400_next      = r400_reg;
        leap_b_next    = leap_b_reg;
        yr_next        = yr_reg;
        acc_next       = acc_reg;
        mon_next       = mon_reg;
        status_next    = status_reg;
        day_out_next   = day_out_reg;
        month_out_next = month_out_reg;
        year_out_next  = year_out_reg;
        day_span_next  = day_span_reg;

        if (accept)
        begin
            // Start transfer: latch the request and begin reducing year A
            func_next = func;
            da_next   = day_a;
            ma_next   = month_a;
            ya_next   = year_a;
            db_next   = day_b;
            mb_next   = month_b;
            yb_next   = year_b;
            cnt_next  = day_count;
            rem_next  = year_a;
            k_next    = RED_TOP;
            pc_next   = S_RED_A;
        end
        else
        begin
            unique case (cur.op)
                OP_NOP:
                begin
                end
                OP_REDUCE:
                begin
                    if (rem_reg >= red_val)
                        rem_next = rem_reg - red_val;
                    if (k_reg != '0)
                        k_next = k_reg - K_W'(1);
                end
                OP_CHECK_A:
                begin
                    r400_next = rem_reg[R400_W-1:0];
                    yr_next   = YR_W'(ya_reg);
                    acc_next  = ACC_W'(day_of_year(da_reg, ma_reg, leap_rem_a));
                end
                OP_LOAD_B:
                begin
                    rem_next = yb_reg;
                    k_next   = RED_TOP;
                end
                OP_CHECK_B:
                begin
                    leap_b_next = leap_rem_b;
                end
                OP_SPAN_INIT:
                begin
                    // May wrap negative; the year walk brings it back into range.
                    acc_next = ACC_W'(day_of_year(db_reg, mb_reg, leap_b_reg)) - acc_reg;
                end
                OP_YEAR_ACC:
                begin
                    if (yr_ne_b)
                    begin
                        acc_next  = acc_reg + ACC_W'(ylen);
                        yr_next   = yr_reg + YR_W'(1);
                        r400_next = r400_inc;
                    end
                end
                OP_ADD_CNT:
                begin
                    acc_next = acc_reg + ACC_W'(cnt_reg);
                end
                OP_YEAR_SUB:
                begin
                    if (year_more)
                    begin
                        acc_next  = acc_reg - ACC_W'(ylen);
                        yr_next   = yr_reg + YR_W'(1);
                        r400_next = r400_inc;
                    end
                end
                OP_MON_INIT:
                begin
                    mon_next = MON_W'(1);
                end
                OP_MON_SUB:
                begin
                    if (mon_more)
                    begin
                        acc_next = acc_reg - ACC_W'(mlen);
                        mon_next = mon_reg + MON_W'(1);
                    end
                end
                OP_FIN_ST:
                begin
                    done_next      = 1'b1;
                    status_next    = cur.status;
                    day_out_next   = '0;
                    month_out_next = '0;
                    year_out_next  = '0;
                    day_span_next  = '0;
                end
                OP_FIN_ADD:
                begin
                    done_next      = 1'b1;
                    status_next    = ST_OK;
                    day_out_next   = acc_reg[DAY_W-1:0] + DAY_W'(1);
                    month_out_next = mon_reg;
                    year_out_next  = yr_reg[YEAR_W-1:0];
                    day_span_next  = '0;
                end
                OP_FIN_SPAN:
                begin
                    done_next      = 1'b1;
                    day_out_next   = '0;
                    month_out_next = '0;
                    year_out_next  = '0;
                    if (acc_reg[ACC_W-1:SPAN_W] != '0)
                    begin
                        status_next   = ST_OVERFLOW;
                        day_span_next = '0;
                    end
                    else
                    begin
                        status_next   = ST_OK;
                        day_span_next = acc_reg[SPAN_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= S_IDLE;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            pc_reg   <= pc_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    // Payload and datapath
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        da_reg        <= da_next;
        ma_reg        <= ma_next;
        ya_reg        <= ya_next;
        db_reg        <= db_next;
        mb_reg        <= mb_next;
        yb_reg        <= yb_next;
        cnt_reg       <= cnt_next;
        rem_reg       <= rem_next;
        r400_reg      <= r400_next;
        leap_b_reg    <= leap_b_next;
        yr_reg        <= yr_next;
        acc_reg       <= acc_next;
        mon_reg       <= mon_next;
        status_reg    <= status_next;
        day_out_reg   <= day_out_next;
        month_out_reg <= month_out_next;
        year_out_reg  <= year_out_next;
        day_span_reg  <= day_span_next;
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign day_out   = day_out_reg;
    assign month_out = month_out_reg;
    assign year_out  = year_out_reg;
    assign day_span  = day_span_reg;

`ifndef NO_ASSERTIONS
    // Every result leaves the sequencer back at idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while sequencer busy");

    // A start transfer always launches the microprogram.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start transfer did not launch sequencer");

    // Failed requests carry no date or span.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |->
            (day_out == '0) && (month_out == '0) && (year_out == '0) && (day_span == '0))
        else $error("error result with nonzero fields");

    // A good add lands on a real month and a nonzero day.
    a_add_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_OK) && (func_reg == FN_ADD)) |->
            (month_out >= MON_W'(1)) && (month_out <= MONTHS) && (day_out != '0))
        else $error("add result outside calendar range");
`endif

endmodule
